// ----- src/spmq_pkg.sv -----
`timescale 1ns / 1ps
package spmq_pkg;

   // request opcodes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // response status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_BADLEVEL = 2'd3;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic commit;    // apply the request to the queue state
      logic load_rsp;  // fill the output register
      logic from_ram;  // response carries a popped word
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_read;  // remove that found a non-empty level
      logic out_free;    // output register can take a new item
   } stat_type;

endpackage

// ----- src/spmq_req_if.sv -----
`timescale 1ns / 1ps
interface spmq_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [1:0]  level;
   logic signed [31:0] value;

   modport source (output valid, output func, output level, output value, input ready);
   modport sink   (input valid, input func, input level, input value, output ready);
endinterface

// ----- src/spmq_rsp_if.sv -----
`timescale 1ns / 1ps
interface spmq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic signed [31:0] out_value;
   logic [1:0]  served_level;

   modport source (output valid, output status, output out_value, output served_level,
                   input ready);
   modport sink   (input valid, input status, input out_value, input served_level,
                   output ready);
endinterface

// ----- src/spmq_ram.sv -----
`timescale 1ns / 1ps
module spmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/spmq_ctrl.sv -----
`timescale 1ns / 1ps
module spmq_ctrl
   import spmq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.needs_read) begin
               // pop: start the slot read, answer once data is back
               cmd.commit = 1'b1;
               state_in   = S_READ;
            end else if (stat.out_free) begin
               cmd.commit   = 1'b1;
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_READ: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               cmd.from_ram = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- src/spmq_datapath.sv -----
`timescale 1ns / 1ps
module spmq_datapath
   import spmq_pkg::*;
#(
   parameter int DEPTH  = 8,
   parameter int LEVELS = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic               req_func,
   input  logic [1:0]         req_level,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_out_value,
   output logic [1:0]         rsp_served_level
);

   localparam int CW = $clog2(DEPTH + 1);   // counters hold 0..DEPTH
   localparam int SW = $clog2(DEPTH);       // slot within a level
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int AW = LW + SW;

   // captured request
   logic               func_ff;
   logic [1:0]         level_ff;
   logic signed [31:0] value_ff;

   // per-level pointers
   logic [CW-1:0] head_ff [LEVELS];
   logic [CW-1:0] head_in [LEVELS];
   logic [CW-1:0] fill_ff [LEVELS];
   logic [CW-1:0] fill_in [LEVELS];

   logic [LW-1:0] pop_level_ff;

   // output register
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic signed [31:0] rsp_value_ff;
   logic [1:0]         rsp_level_ff;

   logic          is_insert;
   logic          bad_level;
   logic          level_full;
   logic [LW-1:0] ins_idx;
   logic          found;
   logic [LW-1:0] pop_idx;
   logic          do_write;
   logic          do_read;
   logic [1:0]    stat_comb;
   logic [1:0]    level_comb;
   logic [AW-1:0] waddr;
   logic [AW-1:0] raddr;
   logic [31:0]   rdata;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         level_ff <= req_level;
         value_ff <= req_value;
      end
   end

   // insert checks
   assign is_insert  = (func_ff == FUNC_INSERT);
   assign bad_level  = (32'(level_ff) >= LEVELS);
   assign ins_idx    = LW'(level_ff);
   assign level_full = (fill_ff[ins_idx] == CW'(DEPTH));

   // first non-empty level, lowest index wins
   always_comb begin
      found   = 1'b0;
      pop_idx = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (head_ff[i] != fill_ff[i]) begin
            found   = 1'b1;
            pop_idx = LW'(i);
         end
      end
   end

   assign stat.needs_read = !is_insert && found;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   assign do_write = cmd.commit && is_insert && !bad_level && !level_full;
   assign do_read  = cmd.commit && !is_insert && found;

   // answer for everything that does not pop
   always_comb begin
      if (!is_insert) begin
         stat_comb  = ST_EMPTY;
         level_comb = 2'd0;
      end else if (bad_level) begin
         stat_comb  = ST_BADLEVEL;
         level_comb = 2'd0;
      end else if (level_full) begin
         stat_comb  = ST_FULL;
         level_comb = level_ff;
      end else begin
         stat_comb  = ST_OK;
         level_comb = level_ff;
      end
   end

   // pointer updates
   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         head_in[i] = head_ff[i];
         fill_in[i] = fill_ff[i];
         if (do_write && ins_idx == LW'(i)) begin
            fill_in[i] = fill_ff[i] + CW'(1);
         end
         if (do_read && pop_idx == LW'(i)) begin
            head_in[i] = head_ff[i] + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= head_in[i];
            fill_ff[i] <= fill_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_read) begin
         pop_level_ff <= pop_idx;
      end
   end

   // slot storage, level-major addressing
   assign waddr = {ins_idx, fill_ff[ins_idx][SW-1:0]};
   assign raddr = {pop_idx, head_ff[pop_idx][SW-1:0]};

   spmq_ram #(
      .WIDTH (32),
      .DEPTH (1 << AW)
   ) u_slots (
      .clock (clock),
      .we    (do_write),
      .waddr (waddr),
      .wdata (value_ff),
      .re    (do_read),
      .raddr (raddr),
      .rdata (rdata)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (cmd.from_ram) begin
            rsp_status_ff <= ST_OK;
            rsp_value_ff  <= rdata;
            rsp_level_ff  <= 2'(pop_level_ff);
         end else begin
            rsp_status_ff <= stat_comb;
            rsp_value_ff  <= '0;
            rsp_level_ff  <= level_comb;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_served_level = rsp_level_ff;

endmodule

// ----- src/strict_priority_multi_queue.sv -----
`timescale 1ns / 1ps
// Strict-priority queue set: LEVELS linear queues of DEPTH words each, level 0
// highest. An insert appends to the named level (status full once that level has
// written its last slot, bad level for codes at or above LEVELS); a remove pops the
// head of the lowest-numbered non-empty level and returns the word and level, or
// reports all empty. Popped slots are not reused until reset. One request is worked
// on at a time: an insert, a rejected request or an empty remove goes through the
// controller's accept and execute states, a successful remove also through a read
// state for the registered read port of the slot memory. The response sits in an
// output register, so a new request is accepted while the previous response waits.
// Storage needs no clearing after reset; the pointers reset at once.
module strict_priority_multi_queue
   import spmq_pkg::*;
#(
   parameter int DEPTH  = 8,
   parameter int LEVELS = 3
) (
   input  logic       clock,
   input  logic       reset,
   spmq_req_if.sink   req_bus,
   spmq_rsp_if.source rsp_bus
);

   cmd_type  cmd;
   stat_type stat;
   logic     ready;

   spmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spmq_datapath #(
      .DEPTH  (DEPTH),
      .LEVELS (LEVELS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_bus.func),
      .req_level        (req_bus.level),
      .req_value        (req_bus.value),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_status       (rsp_bus.status),
      .rsp_out_value    (rsp_bus.out_value),
      .rsp_served_level (rsp_bus.served_level)
   );

   assign req_bus.ready = ready;

endmodule

// ----- src/spmq_checker.sv -----
`timescale 1ns / 1ps
module spmq_checker
   import spmq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_out_value,
   input logic [1:0]  rsp_served_level
);

   // one request in flight: ready drops right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in flight");

   // only a successful pop carries a word
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_out_value == 32'd0)
      else $error("nonzero value on a response other than ok");

   // empty and bad-level answers name level zero
   a_level_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_BADLEVEL)
      |-> rsp_served_level == 2'd0)
      else $error("served level set on empty or bad-level response");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_out_value) && $stable(rsp_served_level))
      else $error("stalled response changed");

endmodule

bind strict_priority_multi_queue spmq_checker u_spmq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_out_value    (rsp_bus.out_value),
   .rsp_served_level (rsp_bus.served_level)
);

// ----- dv/strict_priority_multi_queue_test.sv -----
`timescale 1ns / 1ps
module strict_priority_multi_queue_test;
   import spmq_pkg::*;

   localparam int NUM_LEVELS  = 3;
   localparam int QUEUE_DEPTH = 8;
   localparam int NUM_RANDOM  = 1330;
   localparam int NUM_ROWS    = 23;
   // first level code past the last real level
   localparam logic [1:0] BAD_LEVEL_CODE = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] out_value;
      logic [1:0]  served_level;
   } queue_result_type;

   typedef struct packed {
      logic             func;
      logic [1:0]       level;
      logic [31:0]      value;
      logic             typed;   // expected result given in the row itself
      queue_result_type result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spmq_req_if req_bus ();
   spmq_rsp_if rsp_bus ();

   strict_priority_multi_queue #(
      .DEPTH  (QUEUE_DEPTH),
      .LEVELS (NUM_LEVELS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #4 clock = ~clock;

   // shadow copy of the queue set
   logic [31:0] shadow_words [NUM_LEVELS][QUEUE_DEPTH];
   int shadow_head [NUM_LEVELS];
   int shadow_tail [NUM_LEVELS];

   queue_result_type pending_results[$];
   int error_count = 0;
   bit no_idle = 1'b0;

   stim_row_type directed_rows [NUM_ROWS];

   // apply one request to the shadow queues and return its response
   function automatic queue_result_type apply_queue_op(logic func, logic [1:0] level,
                                                       logic [31:0] value);
      queue_result_type res;
      int lv;
      res = '0;
      if (func == FUNC_INSERT) begin
         if (level >= NUM_LEVELS) begin
            res.status = ST_BADLEVEL;
         end else if (shadow_tail[level] >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
            res.served_level = level;
         end else begin
            shadow_words[level][shadow_tail[level]] = value;
            shadow_tail[level]++;
            res.status = ST_OK;
            res.served_level = level;
         end
      end else begin
         res.status = ST_EMPTY;
         // lowest-numbered non-empty level wins
         for (lv = 0; lv < NUM_LEVELS; lv++) begin
            if (res.status == ST_EMPTY && shadow_head[lv] < shadow_tail[lv]) begin
               res.status = ST_OK;
               res.out_value = shadow_words[lv][shadow_head[lv]];
               res.served_level = lv[1:0];
               shadow_head[lv]++;
            end
         end
      end
      return res;
   endfunction

   // present one request, return at the edge that accepts it
   task automatic send_request(input logic func, input logic [1:0] level,
                               input logic [31:0] value);
      while (!no_idle && $urandom_range(0, 99) < 17) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func  <= func;
      req_bus.level <= level;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // hold off the sender until every response is back
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // response side back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= 17);
      end
   end

   // response checker
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response: status %0d out_value %0d served_level %0d",
                   rsp_bus.status, rsp_bus.out_value, rsp_bus.served_level);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.out_value !== want.out_value) begin
               $error("out_value: expected %0d, got %0d",
                      $signed(want.out_value), rsp_bus.out_value);
               error_count++;
            end
            if (rsp_bus.served_level !== want.served_level) begin
               $error("served_level: expected %0d, got %0d",
                      want.served_level, rsp_bus.served_level);
               error_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      queue_result_type predicted;
      logic             func;
      logic [1:0]       level;
      logic [31:0]      value;
      int n;

      req_bus.valid = 1'b0;
      req_bus.func  = FUNC_INSERT;
      req_bus.level = 2'd0;
      req_bus.value = 32'd0;
      for (n = 0; n < NUM_LEVELS; n++) begin
         shadow_head[n] = 0;
         shadow_tail[n] = 0;
      end

      directed_rows = '{
         // empty after reset, bad level, words in every level at the extremes
         '{FUNC_REMOVE, 2'd0, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'h0, 2'd0}},
         '{FUNC_INSERT, BAD_LEVEL_CODE, 32'h1234_5678, 1'b1,
           '{ST_BADLEVEL, 32'h0, 2'd0}},
         '{FUNC_INSERT, 2'd2, 32'h7FFF_FFFF, 1'b1, '{ST_OK, 32'h0, 2'd2}},
         '{FUNC_INSERT, 2'd1, 32'h8000_0000, 1'b1, '{ST_OK, 32'h0, 2'd1}},
         '{FUNC_INSERT, 2'd0, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0, 2'd0}},
         '{FUNC_INSERT, 2'd0, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0, 2'd0}},
         // removes drain by priority; the level field is ignored
         '{FUNC_REMOVE, 2'd2, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 2'd0}},
         '{FUNC_REMOVE, BAD_LEVEL_CODE, 32'h0, 1'b1, '{ST_OK, 32'h0, 2'd0}},
         '{FUNC_REMOVE, 2'd0, 32'h0, 1'b1, '{ST_OK, 32'h8000_0000, 2'd1}},
         '{FUNC_REMOVE, 2'd1, 32'h0, 1'b1, '{ST_OK, 32'h7FFF_FFFF, 2'd2}},
         '{FUNC_REMOVE, 2'd0, 32'h0, 1'b1, '{ST_EMPTY, 32'h0, 2'd0}},
         // fill level 0 to its last slot; popped slots stay used
         '{FUNC_INSERT, 2'd0, 32'h5555_5555, 1'b0, '0},
         '{FUNC_INSERT, 2'd0, 32'hAAAA_AAAA, 1'b0, '0},
         '{FUNC_INSERT, 2'd0, 32'h0000_0001, 1'b0, '0},
         '{FUNC_INSERT, 2'd0, 32'h0000_FFFF, 1'b0, '0},
         '{FUNC_INSERT, 2'd0, 32'hFFFF_0000, 1'b0, '0},
         '{FUNC_INSERT, 2'd0, 32'h8000_0001, 1'b0, '0},
         '{FUNC_INSERT, 2'd0, 32'hDEAD_BEEF, 1'b1, '{ST_FULL, 32'h0, 2'd0}},
         '{FUNC_INSERT, BAD_LEVEL_CODE, 32'hFFFF_FFFF, 1'b1,
           '{ST_BADLEVEL, 32'h0, 2'd0}},
         '{FUNC_REMOVE, 2'd1, 32'h0, 1'b0, '0},
         '{FUNC_INSERT, 2'd2, 32'h0F0F_0F0F, 1'b0, '0},
         '{FUNC_REMOVE, 2'd0, 32'h0, 1'b0, '0},
         '{FUNC_REMOVE, 2'd3, 32'h0, 1'b0, '0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (n = 0; n < NUM_ROWS; n++) begin
         send_request(directed_rows[n].func, directed_rows[n].level,
                      directed_rows[n].value);
         predicted = apply_queue_op(directed_rows[n].func, directed_rows[n].level,
                                    directed_rows[n].value);
         if (directed_rows[n].typed)
            pending_results.push_back(directed_rows[n].result);
         else
            pending_results.push_back(predicted);
      end
      drain_responses();

      // random traffic; a window in the middle runs with no idling
      for (n = 0; n < NUM_RANDOM; n++) begin
         no_idle = (n >= 300 && n < 600);
         if (n == 800)
            drain_responses();
         func  = ($urandom_range(0, 99) < 50) ? FUNC_REMOVE : FUNC_INSERT;
         level = ($urandom_range(0, 9) == 0) ? BAD_LEVEL_CODE
                                             : 2'($urandom_range(0, NUM_LEVELS - 1));
         if (func == FUNC_REMOVE)
            level = 2'($urandom_range(0, 3));
         value = $urandom;
         send_request(func, level, value);
         pending_results.push_back(apply_queue_op(func, level, value));
      end
      no_idle = 1'b0;
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- strict_priority_multi_queue.f -----
src/spmq_pkg.sv
src/spmq_req_if.sv
src/spmq_rsp_if.sv
src/spmq_ram.sv
src/spmq_ctrl.sv
src/spmq_datapath.sv
src/strict_priority_multi_queue.sv
src/spmq_checker.sv
dv/strict_priority_multi_queue_test.sv
